// File: sv/mes_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mes_pkg
// Shared types and constants for the Morse element sequencer.
// ----------------------------------------------------------------------------
package mes_pkg;

  localparam int DOT_W   = 11;
  localparam int DASH_W  = 13;
  localparam int CFG_W   = 13;
  localparam int TIME_W  = 32;
  localparam int WORD_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 4;
  localparam int COUNT_LSB = 12;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  // register indexes
  localparam logic REG_DOT  = 1'b0;
  localparam logic REG_DASH = 1'b1;

  // key phase codes
  localparam logic [1:0] PHASE_UP  = 2'd0;
  localparam logic [1:0] PHASE_DIT = 2'd1;
  localparam logic [1:0] PHASE_DAH = 2'd2;

  // key action codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_DOWN = 2'd1;
  localparam logic [1:0] ACT_UP   = 2'd2;

  localparam logic [WORD_W-1:0] WORD_SPACE = 16'hd000;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [DOT_W-1:0]  DOT_RESET      = 11'd60;
  localparam logic [DASH_W-1:0] DASH_RESET     = 13'd180;
  localparam logic [TIME_W-1:0] DEADLINE_RESET = 32'd100;

  typedef struct packed {
    logic [WORD_W-1:0] code_word;
    logic [CHAR_W-1:0] char_code;
    logic              char_valid;
    logic              in_serial_mode;
    logic [TIME_W-1:0] now_ms;
  } mes_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] show_char;
    logic              show_valid;
    logic              char_taken;
    logic              serial_mode_out;
    logic [1:0]        key_action;
  } mes_result_t;

endpackage
`default_nettype wire

// File: sv/mes_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mes_core
// Sequencer state, timing registers and the one-step update logic.
// ----------------------------------------------------------------------------
module mes_core #(
  parameter int ELEMENT_BITS = 12
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire                       cfg_addr,
  input  wire [mes_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire                       upd,
  input  wire mes_pkg::mes_item_t   item,
  output mes_pkg::mes_result_t      result
);
  import mes_pkg::*;

  logic [DOT_W-1:0]        dot_ticks;
  logic [DASH_W-1:0]       dash_ticks;
  logic [1:0]              key_phase, key_phase_next;
  logic [ELEMENT_BITS-1:0] element_bits, element_bits_next;
  logic [COUNT_W-1:0]      elements_left, elements_left_next;
  logic [TIME_W-1:0]       deadline_ms, deadline_ms_next;
  logic                    serial;

  always_comb begin
    key_phase_next     = key_phase;
    element_bits_next  = element_bits;
    elements_left_next = elements_left;
    deadline_ms_next   = deadline_ms;
    serial             = item.in_serial_mode;
    result             = '0;

    if ((item.now_ms >= deadline_ms) && serial) begin
      if (key_phase == PHASE_UP) begin
        result.key_action = ACT_DOWN;
        if (element_bits[0]) begin
          key_phase_next   = PHASE_DAH;
          deadline_ms_next = item.now_ms + TIME_W'(dash_ticks);
        end else begin
          key_phase_next   = PHASE_DIT;
          deadline_ms_next = item.now_ms + TIME_W'(dot_ticks);
        end
      end else begin
        result.key_action = ACT_UP;
        key_phase_next    = PHASE_UP;
        if (elements_left > COUNT_W'(1)) begin
          elements_left_next = elements_left - COUNT_W'(1);
          element_bits_next  = element_bits >> 1;
          deadline_ms_next   = item.now_ms + TIME_W'(dot_ticks);
        end else begin
          elements_left_next = '0;
          deadline_ms_next   = item.now_ms + TIME_W'(dash_ticks);
          serial             = 1'b0;
        end
      end
    end

    if (!serial && item.char_valid) begin
      result.char_taken = 1'b1;
      if (item.code_word == WORD_SPACE) begin
        serial             = 1'b1;
        key_phase_next     = PHASE_DAH;
        elements_left_next = COUNT_W'(1);
        deadline_ms_next   = item.now_ms + TIME_W'(dash_ticks) + TIME_W'(dot_ticks);
        result.show_valid  = 1'b1;
        result.show_char   = CHAR_SPACE;
      end else if ((item.code_word != '0) && (item.code_word < WORD_SPACE)) begin
        serial             = 1'b1;
        elements_left_next = item.code_word[COUNT_LSB +: COUNT_W];
        element_bits_next  = item.code_word[ELEMENT_BITS-1:0];
        result.show_valid  = 1'b1;
        result.show_char   = item.char_code;
      end
    end

    result.serial_mode_out = serial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks  <= DOT_RESET;
      dash_ticks <= DASH_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DOT:  dot_ticks  <= cfg_wdata[DOT_W-1:0];
        REG_DASH: dash_ticks <= cfg_wdata[DASH_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_phase     <= PHASE_UP;
      element_bits  <= '0;
      elements_left <= '0;
      deadline_ms   <= DEADLINE_RESET;
    end else if (upd) begin
      key_phase     <= key_phase_next;
      element_bits  <= element_bits_next;
      elements_left <= elements_left_next;
      deadline_ms   <= deadline_ms_next;
    end
  end

`ifndef SYNTHESIS
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    key_phase != 2'd3) else $error("key phase out of range");

  a_down_leaves_up: assert property (@(posedge clk) disable iff (rst)
    (upd && result.key_action == ACT_DOWN) |=> (key_phase != PHASE_UP))
    else $error("key down did not leave up phase");

  a_up_enters_up: assert property (@(posedge clk) disable iff (rst)
    (upd && result.key_action == ACT_UP && !result.char_taken) |=> (key_phase == PHASE_UP))
    else $error("key up did not return to up phase");
`endif

endmodule
`default_nettype wire

// File: sv/morse_element_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// morse_element_sequencer
// Serial-mode Morse sender: times dits, dahs and gaps per update request.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ side is one update: current ms time, the keyer
//   mode, and an optional character with its code word. Each request yields
//   exactly one result on the m_ side: key action, returned mode, whether the
//   character was taken, and the character to display. The user must write
//   dot_ticks (index 0) and dash_ticks (index 1) through cfg_we /
//   cfg_addr / cfg_wdata only while no request is in flight; not enforced.
// Timing:
//   A request is registered on acceptance into the input stage, evaluated
//   against the sequencer state once it can advance, and lands in the result
//   register, from which the result is presented. One request per cycle is
//   sustained while m_tready stays high.
// Reset:
//   rst (synchronous) clears both stages, sets key up, no elements pending,
//   deadline 100 ms, dot 60 ms and dash 180 ms.
// Stall:
//   While m_tready is low the result holds; the input stage still fills,
//   then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module morse_element_sequencer #(
  parameter int ELEMENT_BITS = 12
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire                             cfg_addr,
  input  wire [mes_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // now_ms[31:0], in_serial_mode[32], char_valid[33], char_code[41:34],
  // code_word[57:42], zero[63:58]
  input  wire [mes_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // key_action[1:0], serial_mode_out[2], char_taken[3], show_valid[4],
  // show_char[12:5], zero[15:13]
  output logic [mes_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mes_pkg::*;

  localparam int ITEM_W   = $bits(mes_item_t);
  localparam int RESULT_W = $bits(mes_result_t);

  logic        in_valid;
  mes_item_t   in_item;
  logic        advance;
  logic        upd;
  mes_result_t step_result;
  mes_result_t out_result;

  assign advance  = !m_tvalid || m_tready;
  assign upd      = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= mes_item_t'(s_tdata[ITEM_W-1:0]);
    end
  end

  mes_core #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .upd       (upd),
    .item      (in_item),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_result};

`ifndef SYNTHESIS
  a_action_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_result.key_action != 2'd3)) else $error("bad key action");

  a_show_needs_take: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_result.show_valid) |-> (out_result.char_taken && out_result.serial_mode_out))
    else $error("display without taken character");

  a_show_char_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_result.show_valid) |-> (out_result.show_char == '0))
    else $error("display character not cleared");
`endif

endmodule
`default_nettype wire
